// ===== src/dce_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the chord encoding function for the
// debounced chord encoder. No dependencies.
package dce_pkg;

    localparam int QUIET_BITS = 16;
    localparam int TICKS_W    = 16;
    localparam int CMP_W      = (QUIET_BITS > TICKS_W) ? QUIET_BITS : TICKS_W;
    localparam int ADDR_W     = 3;

    typedef logic [QUIET_BITS-1:0] t_quiet;
    typedef logic [TICKS_W-1:0]    t_ticks;

    localparam t_quiet QUIET_MAX = {QUIET_BITS{1'b1}};

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [ADDR_W-3:0] REG_DEBOUNCE = '0;

    localparam t_ticks     DEBOUNCE_RESET = 16'd50;
    localparam logic [3:0] SLOT_A_RESET   = 4'd8;
    localparam logic [3:0] SLOT_B_RESET   = 4'd9;

    typedef struct packed {
        logic [2:0] prev_raw;
        logic [2:0] stable_levels;
        t_quiet     quiet_count;
        logic [2:0] current_code;
        logic [2:0] counted_code;
        logic       slot_parity;
        logic [3:0] first_slot;
        logic [3:0] second_slot;
    } t_state;

    function automatic logic [2:0] chord_encode(input logic [2:0] pressed);
        logic [2:0] code;
        case (pressed)
            3'b001:  code = 3'd1;
            3'b010:  code = 3'd2;
            3'b100:  code = 3'd3;
            3'b011:  code = 3'd4;
            3'b101:  code = 3'd5;
            3'b110:  code = 3'd6;
            3'b111:  code = 3'd7;
            default: code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

// ===== src/dce_cfg.sv =====
`timescale 1ns / 1ps
// APB-style configuration register holding the debounce setting.
// Depends on dce_pkg.
module dce_cfg
    import dce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_ticks            o_debounce_ticks
);

    t_ticks r_ticks;
    logic   w_hit;

    assign w_hit  = (paddr[ADDR_W-1:2] == REG_DEBOUNCE);
    assign pready = 1'b1;
    assign prdata = w_hit ? {{(32-TICKS_W){1'b0}}, r_ticks} : 32'd0;
    assign o_debounce_ticks = r_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= DEBOUNCE_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_ticks <= pwdata[TICKS_W-1:0];
        end
    end

endmodule

// ===== src/dce_step.sv =====
`timescale 1ns / 1ps
// Next-state logic for one request: debounce, chord encoding, slot update.
// Depends on dce_pkg.
module dce_step
    import dce_pkg::*;
(
    input  t_state     i_state,
    input  t_ticks     i_debounce_ticks,
    input  logic       i_operation,
    input  logic [2:0] i_raw_levels,
    output t_state     o_state,
    output logic       o_changed
);

    t_quiet     w_quiet;
    logic [2:0] w_pressed;
    logic [2:0] w_code;
    logic       w_changed;
    logic       w_parity;

    always_comb begin
        if (i_raw_levels != i_state.prev_raw) begin
            w_quiet = '0;
        end else if (i_state.quiet_count != QUIET_MAX) begin
            w_quiet = i_state.quiet_count + 1'b1;
        end else begin
            w_quiet = i_state.quiet_count;
        end
        w_pressed = ~i_raw_levels;
        w_changed = (CMP_W'(w_quiet) > CMP_W'(i_debounce_ticks))
                    && (i_raw_levels != i_state.stable_levels);
        w_code    = (w_changed && (w_pressed != 3'd0)) ? chord_encode(w_pressed)
                                                       : i_state.current_code;
        w_parity  = i_state.slot_parity ^ (w_code != i_state.counted_code);

        o_state   = i_state;
        o_changed = 1'b0;
        if (i_operation == OP_CLEAR) begin
            o_state.first_slot  = 4'd0;
            o_state.second_slot = 4'd0;
        end else begin
            o_state.quiet_count = w_quiet;
            o_state.prev_raw    = i_raw_levels;
            o_changed           = w_changed;
            if (w_changed) begin
                o_state.stable_levels = i_raw_levels;
                o_state.current_code  = w_code;
                o_state.counted_code  = w_code;
                o_state.slot_parity   = w_parity;
                if (w_parity) begin
                    o_state.second_slot = {1'b0, w_code};
                end else begin
                    o_state.first_slot = {1'b0, w_code};
                end
            end
        end
    end

endmodule

// ===== src/debounced_chord_encoder_latch_core.sv =====
`timescale 1ns / 1ps
// Top level of the debounced chord encoder: state registers, result register.
// Depends on dce_pkg, dce_cfg and dce_step.
//
// Usage:
//   Input channel i_valid/o_ready carries one request per item: i_operation
//   (tick or clear) and i_raw_levels (three active-low buttons).
//   Output channel o_valid/i_ready returns one result per request: both
//   slots, the latest chord code and the changed flag, all after the item.
//   o_valid rises in the cycle after acceptance. Throughput is one request
//   per cycle while the receiver takes each result; the single next-state
//   pass and the result register set that rate.
//   When the receiver stalls, the result holds and o_ready stays high only
//   if the result is taken in the same cycle, so at most one result waits.
//   Synchronous active-low reset clears the debounce state, sets slot A to
//   8, slot B to 9, the debounce setting to 50 and empties the result stage.
//   The debounce setting is written through the APB port at address 0. The
//   user does so only while the block is idle; the block does not enforce it.
module debounced_chord_encoder_latch_core
    import dce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_operation,
    input  logic [2:0]        i_raw_levels,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_slot_a,
    output logic [3:0]        o_slot_b,
    output logic [2:0]        o_chord_code,
    output logic              o_changed,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   r_changed;
    logic   n_changed;
    t_ticks w_ticks;
    logic   w_in_acc;

    dce_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_debounce_ticks (w_ticks)
    );

    dce_step u_step (
        .i_state          (r_state),
        .i_debounce_ticks (w_ticks),
        .i_operation      (i_operation),
        .i_raw_levels     (i_raw_levels),
        .o_state          (n_state),
        .o_changed        (n_changed)
    );

    assign o_ready  = !r_out_valid || i_ready;
    assign w_in_acc = i_valid && o_ready;

    assign o_valid      = r_out_valid;
    assign o_slot_a     = r_state.first_slot;
    assign o_slot_b     = r_state.second_slot;
    assign o_chord_code = r_state.current_code;
    assign o_changed    = r_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.prev_raw      <= 3'd0;
            r_state.stable_levels <= 3'd0;
            r_state.quiet_count   <= '0;
            r_state.current_code  <= 3'd0;
            r_state.counted_code  <= 3'd0;
            r_state.slot_parity   <= 1'b0;
            r_state.first_slot    <= SLOT_A_RESET;
            r_state.second_slot   <= SLOT_B_RESET;
            r_out_valid           <= 1'b0;
            r_changed             <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_state     <= n_state;
                r_changed   <= n_changed;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_operation == OP_CLEAR)
        |=> (o_slot_a == 4'd0) && (o_slot_b == 4'd0) && !o_changed)
        else $error("clear request did not zero both slots");

    a_quiet_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_operation == OP_TICK) && (i_raw_levels == r_state.prev_raw)
        && (r_state.quiet_count != QUIET_MAX)
        |=> r_state.quiet_count == $past(r_state.quiet_count) + 1'b1)
        else $error("quiet counter did not advance");

    a_change_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_changed |-> r_state.stable_levels == r_state.prev_raw)
        else $error("change flagged but stable levels differ from last sample");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_valid)
        else $error("accepted request produced no result");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for debounced_chord_encoder_latch_core: directed table, top-setting
// hold and random press sequences under four idle patterns. Depends on dce_pkg and the DUT.
module tb_top;
    import dce_pkg::*;

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 3;
    localparam int MAX_REPORTS    = 40;
    localparam int SEND_GAP_PCT   = 60;
    localparam int RECV_STALL_PCT = 60;
    localparam int BOTH_IDLE_PCT  = 16;
    localparam int CLEAR_PCT      = 6;
    localparam int NOISE_PCT      = 10;
    localparam int SHORT_HOLD_PCT = 15;
    localparam int REG_UNUSED     = 1;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 160;
    localparam int TOP_HOLD       = 8;

    localparam logic [ADDR_W-1:0] ADDR_DEBOUNCE = ADDR_W'(REG_DEBOUNCE) << 2;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED   = ADDR_W'(REG_UNUSED) << 2;

    localparam t_ticks     RESET_TICKS  = 16'd50;
    localparam logic [3:0] RESET_SLOT_A = 4'd8;
    localparam logic [3:0] RESET_SLOT_B = 4'd9;
    localparam logic [2:0] CODE_OF_PRESSED [8] = '{3'd0, 3'd1, 3'd2, 3'd4,
                                                    3'd3, 3'd5, 3'd6, 3'd7};

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;
    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [3:0] slot_a;
        logic [3:0] slot_b;
        logic [2:0] code;
        logic       changed;
    } t_chord_result;

    typedef struct packed {
        logic [2:0] last_raw;
        logic [2:0] settled;
        t_quiet     quiet;
        logic [2:0] code;
        logic [2:0] code_seen;
        logic       parity;
        logic [3:0] slot_a;
        logic [3:0] slot_b;
    } t_chord_state;

    typedef struct packed {
        t_row_kind         kind;
        logic              op;
        logic [2:0]        raw;
        logic              typed;
        t_chord_result     want;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } t_dir_row;

    localparam t_chord_result AFTER_RESET = '{RESET_SLOT_A, RESET_SLOT_B, 3'd0, 1'b0};
    localparam t_chord_result ALL_CLEAR   = '{4'd0, 4'd0, 3'd0, 1'b0};
    localparam t_chord_state  CHORD_RESET = '{3'd0, 3'd0, '0, 3'd0, 3'd0, 1'b0,
                                              RESET_SLOT_A, RESET_SLOT_B};

    localparam int NUM_DIRECTED = 26;
    localparam t_dir_row DIRECTED [NUM_DIRECTED] = '{
        '{ROW_ITEM, OP_TICK,  3'd0, 1'b1, AFTER_RESET, ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd7, 1'b1, AFTER_RESET, ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_CLEAR, 3'd5, 1'b1, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_CFG,  OP_TICK,  3'd0, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'hFFFF_0000},
        '{ROW_CFG,  OP_TICK,  3'd0, 1'b0, ALL_CLEAR,   ADDR_UNUSED,   32'h0000_0003},
        '{ROW_ITEM, OP_TICK,  3'd7, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd6, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd6, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd2, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd4, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd4, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd3, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd3, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd2, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd2, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd1, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd1, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd0, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd0, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd5, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd5, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd7, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd7, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd5, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_TICK,  3'd5, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0},
        '{ROW_ITEM, OP_CLEAR, 3'd2, 1'b0, ALL_CLEAR,   ADDR_DEBOUNCE, 32'd0}
    };

    localparam int PHASE_TICKS [NUM_PHASES] = '{0, 1, 2, 3, 5, 0, 4, 1};

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_ready;
    logic              i_operation  = OP_TICK;
    logic [2:0]        i_raw_levels = 3'd0;
    logic              o_valid;
    logic              i_ready      = 1'b1;
    logic [3:0]        o_slot_a;
    logic [3:0]        o_slot_b;
    logic [2:0]        o_chord_code;
    logic              o_changed;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;

    t_idle_mode    idle_mode        = IDLE_NONE;
    logic          row_typed        = 1'b0;
    t_chord_result row_want         = ALL_CLEAR;
    t_chord_state  chord_st         = CHORD_RESET;
    t_ticks        debounce_setting = RESET_TICKS;
    t_chord_result expected_chords [$];
    int            mismatches       = 0;
    int            cycle_count      = 0;

    debounced_chord_encoder_latch_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_raw_levels (i_raw_levels),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_slot_a     (o_slot_a),
        .o_slot_b     (o_slot_b),
        .o_chord_code (o_chord_code),
        .o_changed    (o_changed),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (idle_mode == IDLE_RECV) begin
            i_ready <= ($urandom_range(0, 99) >= RECV_STALL_PCT);
        end else if (idle_mode == IDLE_BOTH) begin
            i_ready <= ($urandom_range(0, 99) >= BOTH_IDLE_PCT);
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    function automatic t_chord_result debounce_and_encode(input logic op, input logic [2:0] raw);
        t_chord_result res;
        logic [2:0]    pressed;
        res.changed = 1'b0;
        if (op == OP_CLEAR) begin
            chord_st.slot_a = 4'd0;
            chord_st.slot_b = 4'd0;
        end else begin
            if (raw != chord_st.last_raw) begin
                chord_st.quiet = '0;
            end else if (chord_st.quiet != {QUIET_BITS{1'b1}}) begin
                chord_st.quiet = chord_st.quiet + 1'b1;
            end
            if (64'(chord_st.quiet) > 64'(debounce_setting) && raw != chord_st.settled) begin
                res.changed      = 1'b1;
                chord_st.settled = raw;
                pressed          = ~raw;
                if (pressed != 3'd0) begin
                    chord_st.code = CODE_OF_PRESSED[pressed];
                end
            end
            chord_st.last_raw = raw;
            if (res.changed) begin
                if (chord_st.code != chord_st.code_seen) begin
                    chord_st.parity    = ~chord_st.parity;
                    chord_st.code_seen = chord_st.code;
                end
                if (chord_st.parity) begin
                    chord_st.slot_b = {1'b0, chord_st.code};
                end else begin
                    chord_st.slot_a = {1'b0, chord_st.code};
                end
            end
        end
        res.slot_a = chord_st.slot_a;
        res.slot_b = chord_st.slot_b;
        res.code   = chord_st.code;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_chord_result want;
        t_chord_result pred;
        if (!i_rst_n) begin
            chord_st         = CHORD_RESET;
            debounce_setting = RESET_TICKS;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_chords.size() == 0) begin
                    report_mismatch("result with no request pending", 0, 0);
                end else begin
                    want = expected_chords.pop_front();
                    if (o_slot_a !== want.slot_a)
                        report_mismatch("slot_a", o_slot_a, want.slot_a);
                    if (o_slot_b !== want.slot_b)
                        report_mismatch("slot_b", o_slot_b, want.slot_b);
                    if (o_chord_code !== want.code)
                        report_mismatch("chord_code", o_chord_code, want.code);
                    if (o_changed !== want.changed)
                        report_mismatch("changed", o_changed, want.changed);
                end
            end
            if (i_valid && o_ready) begin
                pred = debounce_and_encode(i_operation, i_raw_levels);
                expected_chords.push_back(row_typed ? row_want : pred);
            end
        end
    end

    task automatic send_request(input logic op, input logic [2:0] raw, input logic typed,
                                input t_chord_result want);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? SEND_GAP_PCT :
                  (idle_mode == IDLE_BOTH) ? BOTH_IDLE_PCT : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_raw_levels <= raw;
        row_typed    <= typed;
        row_want     <= want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chords.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_debounce_reg();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DEBOUNCE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(debounce_setting))
            report_mismatch("debounce_ticks readback", prdata, debounce_setting);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_DEBOUNCE)
            debounce_setting = data[TICKS_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        check_debounce_reg();
    endtask

    task automatic run_press_phase(input int ticks, input t_idle_mode mode, input int n_items);
        int         sent;
        int         hold;
        int         roll;
        logic [2:0] target;
        write_reg(ADDR_DEBOUNCE, {16'($urandom), 16'(ticks)});
        idle_mode = mode;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < CLEAR_PCT) begin
                send_request(OP_CLEAR, 3'($urandom), 1'b0, ALL_CLEAR);
                sent++;
            end else if (roll < CLEAR_PCT + NOISE_PCT) begin
                send_request(OP_TICK, 3'($urandom), 1'b0, ALL_CLEAR);
                sent++;
            end else begin
                target = 3'($urandom);
                repeat ($urandom_range(0, 3)) begin
                    send_request(OP_TICK, 3'($urandom), 1'b0, ALL_CLEAR);
                    sent++;
                end
                if ($urandom_range(0, 99) < SHORT_HOLD_PCT)
                    hold = $urandom_range(1, ticks + 1);
                else
                    hold = ticks + 2 + $urandom_range(0, 2);
                repeat (hold) begin
                    send_request(OP_TICK, target, 1'b0, ALL_CLEAR);
                    sent++;
                end
            end
        end
        drain_results();
    endtask

    initial begin
        int         r;
        int         p;
        logic [2:0] held;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_debounce_reg();

        for (r = 0; r < NUM_DIRECTED; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                drain_results();
                write_reg(DIRECTED[r].addr, DIRECTED[r].data);
            end else begin
                send_request(DIRECTED[r].op, DIRECTED[r].raw, DIRECTED[r].typed,
                             DIRECTED[r].want);
            end
        end
        drain_results();

        // hold a new level at the top setting: never stable
        idle_mode = IDLE_NONE;
        held = chord_st.settled ^ 3'b011;
        write_reg(ADDR_DEBOUNCE, 32'(QUIET_MAX));
        repeat (TOP_HOLD) send_request(OP_TICK, held, 1'b0, ALL_CLEAR);
        drain_results();

        for (p = 0; p < NUM_PHASES; p++) begin
            run_press_phase(PHASE_TICKS[p], t_idle_mode'(p % 4), PHASE_ITEMS);
        end

        if (mismatches == 0 && expected_chords.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
